### sv/imed_pkg.sv
package imed_pkg;

  // raw reading and per-lane widths
  localparam int RAW_W   = 16;
  localparam int GYRO_W  = 21;
  localparam int ACCEL_W = 19;
  localparam int MAG_W   = 20;
  localparam int SQ_W    = 39;
  localparam int SUM_W   = 41;
  localparam int CMP_W   = 42;
  localparam int CNT_W   = 16;
  localparam int AXES    = 3;

  // stream widths
  localparam int IN_TDATA_W  = 6 * RAW_W;
  localparam int IN_TUSER_W  = 3;
  localparam int HELD_W      = AXES * (GYRO_W + ACCEL_W);
  localparam int OUT_TDATA_W = HELD_W + CNT_W;
  localparam int OUT_TUSER_W = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [2:0]  GYRO_SHIFT_MAX      = 3'd4;
  localparam logic [1:0]  ACCEL_SHIFT_RST     = 2'd0;
  localparam logic [2:0]  GYRO_SHIFT_RST      = 3'd0;
  localparam logic [15:0] ONE_G_RST           = 16'd16393;
  localparam logic [17:0] ACCEL_THR_RST       = 18'd8197;
  localparam logic [20:0] GYRO_THR_RST        = 21'd22857;

  // in_tuser bits
  localparam int TU_ACCEL_READY = 0;
  localparam int TU_GYRO_READY  = 1;
  localparam int TU_BUS_ERROR   = 2;

  // out_tuser bits
  localparam int TU_SAMPLE_VALID = 0;
  localparam int TU_MOTION_EVENT = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_SHIFT = 3'd0,
    CFG_GYRO_SHIFT  = 3'd1,
    CFG_ONE_G       = 3'd2,
    CFG_ACCEL_THR   = 3'd3,
    CFG_GYRO_THR    = 3'd4
  } imed_cfg_idx_t;

  // stage enables shared by the lanes and the merge stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } imed_en_t;

  // result fields carried alongside the lane pipeline
  typedef struct packed {
    logic              fresh;
    logic [CNT_W-1:0]  count;
    logic [HELD_W-1:0] held;
  } imed_payload_t;

endpackage

### sv/imed_lane.sv
module imed_lane (
  input  logic                                clk,
  input  imed_pkg::imed_en_t                  en,
  input  logic signed [imed_pkg::RAW_W-1:0]   raw,
  input  logic [2:0]                          shift,
  output logic signed [imed_pkg::GYRO_W-1:0]  scaled,
  output logic [imed_pkg::SQ_W-1:0]           sq
);
  import imed_pkg::*;

  logic [RAW_W:0]     abs_raw;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [2*MAG_W-1:0] prod;
  logic [SQ_W-1:0]    sq_r, sq_nxt;

  always_comb begin
    scaled  = $signed({{(GYRO_W-RAW_W){raw[RAW_W-1]}}, raw}) <<< shift;
    // magnitude taken on the raw reading, then scaled; the most negative value is exact
    abs_raw = raw[RAW_W-1] ? ({1'b0, ~raw} + (RAW_W+1)'(1)) : {1'b0, raw};
    mag_nxt = MAG_W'(abs_raw) << shift;
    prod    = mag_r * mag_r;
    sq_nxt  = prod[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mag_r <= mag_nxt;
    end
    if (en.s2) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq = sq_r;

endmodule

### sv/imed_merge.sv
module imed_merge (
  input  logic                        clk,
  input  imed_pkg::imed_en_t          en,
  input  logic [imed_pkg::SQ_W-1:0]   gyro_sq [imed_pkg::AXES],
  input  logic [imed_pkg::SQ_W-1:0]   accel_sq [imed_pkg::AXES],
  input  logic [15:0]                 one_g,
  input  logic [17:0]                 accel_thr,
  input  logic [20:0]                 gyro_thr,
  output logic                        motion_hit
);
  import imed_pkg::*;

  logic [18:0]      hi;
  logic [15:0]      lo;
  logic             lo_ok_nxt, lo_ok_r;
  logic [37:0]      hi_sq_r, hi_sq_nxt;
  logic [31:0]      lo_sq_r, lo_sq_nxt;
  logic [41:0]      gt_sq_r, gt_sq_nxt;
  logic [SUM_W-1:0] gsum_r, gsum_nxt;
  logic [SUM_W-1:0] asum_r, asum_nxt;

  // bound squares follow the config registers every cycle
  always_comb begin
    hi        = 19'(one_g) + 19'(accel_thr);
    lo_ok_nxt = 18'(one_g) >= accel_thr;
    lo        = one_g - accel_thr[15:0];
    hi_sq_nxt = hi * hi;
    lo_sq_nxt = lo * lo;
    gt_sq_nxt = gyro_thr * gyro_thr;
    gsum_nxt  = SUM_W'(gyro_sq[0]) + SUM_W'(gyro_sq[1]) + SUM_W'(gyro_sq[2]);
    asum_nxt  = SUM_W'(accel_sq[0]) + SUM_W'(accel_sq[1]) + SUM_W'(accel_sq[2]);
  end

  always_ff @(posedge clk) begin
    hi_sq_r <= hi_sq_nxt;
    lo_sq_r <= lo_sq_nxt;
    lo_ok_r <= lo_ok_nxt;
    gt_sq_r <= gt_sq_nxt;
    if (en.s3) begin
      gsum_r <= gsum_nxt;
      asum_r <= asum_nxt;
    end
  end

  assign motion_hit = (CMP_W'(asum_r) >= CMP_W'(hi_sq_r))
                   || (lo_ok_r && (CMP_W'(asum_r) <= CMP_W'(lo_sq_r)))
                   || (CMP_W'(gsum_r) >= gt_sq_r);

endmodule

### sv/imu_motion_event_detector_unit.sv
// channel  | ports          | content
// ---------+----------------+-------------------------------------------------------
// input    | in_t*          | tdata: gyro x,y,z raw, accel x,y,z raw (16b each)
//          |                | tuser: accel_ready, gyro_ready, bus_error
// result   | out_t*         | tdata: gyro x,y,z (21b), accel x,y,z (19b), failure count
//          |                | tuser: sample_valid, motion_event
// config   | cfg_*          | index 0..4 and write data, always ready
//
// one item per cycle unless the output stalls; a result goes from its input transfer through
// scale/abs, square per lane, three-way sum, compare into the output register.
// held values and the failure counter update at the input transfer itself.
// each stage moves when the one after it is empty or moving, so bubbles collapse
// and input keeps flowing while a result waits, until the stages fill. reset clears the held values,
// the counter, the config registers and all stage valids.
module imu_motion_event_detector_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [imed_pkg::IN_TDATA_W-1:0]      in_tdata,  // gyro x,y,z, accel x,y,z
  input  logic [imed_pkg::IN_TUSER_W-1:0]      in_tuser,  // accel_ready, gyro_ready, bus_error
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [imed_pkg::OUT_TDATA_W-1:0]     out_tdata, // gyro x,y,z, accel x,y,z, failure_count
  output logic [imed_pkg::OUT_TUSER_W-1:0]     out_tuser, // sample_valid, motion_event
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [imed_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [imed_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import imed_pkg::*;

  logic [1:0]  accel_shift_r;
  logic [2:0]  gyro_shift_r;
  logic [15:0] one_g_r;
  logic [17:0] accel_thr_r;
  logic [20:0] gyro_thr_r;
  logic [2:0]  gyro_shift_sat;

  logic signed [GYRO_W-1:0]  held_gyro_r [AXES];
  logic signed [GYRO_W-1:0]  held_gyro_nxt [AXES];
  logic signed [ACCEL_W-1:0] held_accel_r [AXES];
  logic signed [ACCEL_W-1:0] held_accel_nxt [AXES];
  logic [CNT_W-1:0]          err_cnt_r, err_cnt_nxt;

  logic signed [GYRO_W-1:0] gyro_scaled [AXES];
  logic signed [GYRO_W-1:0] accel_scaled [AXES];
  logic [SQ_W-1:0]          gyro_sq [AXES];
  logic [SQ_W-1:0]          accel_sq [AXES];

  imed_en_t      en;
  logic          en_out;
  logic          in_xfer, fresh, bus_err;
  logic          v1_r, v2_r, v3_r, vo_r;
  imed_payload_t pay_in, pay1_r, pay2_r, pay3_r, payo_r;
  logic          event_o_r;
  logic          motion_hit;

  // stage advance: a stage loads when it is empty or its content moves on
  always_comb begin
    en_out    = !vo_r || out_tready;
    en.s3     = !v3_r || en_out;
    en.s2     = !v2_r || en.s3;
    en.s1     = !v1_r || en.s2;
    in_tready = en.s1;
    in_xfer   = in_tvalid && in_tready;
    cfg_ready = 1'b1;
  end

  always_comb begin
    gyro_shift_sat = (gyro_shift_r inside {[3'd5:3'd7]}) ? GYRO_SHIFT_MAX : gyro_shift_r;
  end

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    imed_lane u_gyro (
      .clk    (clk),
      .en     (en),
      .raw    ($signed(in_tdata[i*RAW_W +: RAW_W])),
      .shift  (gyro_shift_sat),
      .scaled (gyro_scaled[i]),
      .sq     (gyro_sq[i])
    );
    imed_lane u_accel (
      .clk    (clk),
      .en     (en),
      .raw    ($signed(in_tdata[(AXES+i)*RAW_W +: RAW_W])),
      .shift  ({1'b0, accel_shift_r}),
      .scaled (accel_scaled[i]),
      .sq     (accel_sq[i])
    );
  end

  imed_merge u_merge (
    .clk        (clk),
    .en         (en),
    .gyro_sq    (gyro_sq),
    .accel_sq   (accel_sq),
    .one_g      (one_g_r),
    .accel_thr  (accel_thr_r),
    .gyro_thr   (gyro_thr_r),
    .motion_hit (motion_hit)
  );

  // held state and counter after the item at the input
  always_comb begin
    bus_err = in_tuser[TU_BUS_ERROR];
    fresh   = in_tuser[TU_ACCEL_READY] && in_tuser[TU_GYRO_READY] && !bus_err;
    err_cnt_nxt = err_cnt_r;
    if (in_xfer && bus_err && (err_cnt_r != {CNT_W{1'b1}})) begin
      err_cnt_nxt = err_cnt_r + CNT_W'(1);
    end
    for (int i = 0; i < AXES; i++) begin
      held_gyro_nxt[i]  = held_gyro_r[i];
      held_accel_nxt[i] = held_accel_r[i];
      if (in_xfer && fresh) begin
        held_gyro_nxt[i]  = gyro_scaled[i];
        held_accel_nxt[i] = accel_scaled[i][ACCEL_W-1:0];
      end
    end
    pay_in.fresh = fresh;
    pay_in.count = err_cnt_nxt;
    pay_in.held  = {held_accel_nxt[2], held_accel_nxt[1], held_accel_nxt[0],
                    held_gyro_nxt[2], held_gyro_nxt[1], held_gyro_nxt[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_cnt_r <= '0;
      for (int i = 0; i < AXES; i++) begin
        held_gyro_r[i]  <= '0;
        held_accel_r[i] <= '0;
      end
    end else begin
      err_cnt_r <= err_cnt_nxt;
      for (int i = 0; i < AXES; i++) begin
        held_gyro_r[i]  <= held_gyro_nxt[i];
        held_accel_r[i] <= held_accel_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_shift_r <= ACCEL_SHIFT_RST;
      gyro_shift_r  <= GYRO_SHIFT_RST;
      one_g_r       <= ONE_G_RST;
      accel_thr_r   <= ACCEL_THR_RST;
      gyro_thr_r    <= GYRO_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (imed_cfg_idx_t'(cfg_index))
        CFG_ACCEL_SHIFT: accel_shift_r <= cfg_data[1:0];
        CFG_GYRO_SHIFT:  gyro_shift_r  <= cfg_data[2:0];
        CFG_ONE_G:       one_g_r       <= cfg_data[15:0];
        CFG_ACCEL_THR:   accel_thr_r   <= cfg_data[17:0];
        CFG_GYRO_THR:    gyro_thr_r    <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_xfer;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en_out) vo_r <= v3_r;
    end
  end

  // result payload travels beside the lane pipeline
  always_ff @(posedge clk) begin
    if (en.s1) pay1_r <= pay_in;
    if (en.s2) pay2_r <= pay1_r;
    if (en.s3) pay3_r <= pay2_r;
    if (en_out) begin
      payo_r    <= pay3_r;
      event_o_r <= pay3_r.fresh && motion_hit;
    end
  end

  assign out_tvalid                 = vo_r;
  assign out_tdata                  = {payo_r.count, payo_r.held};
  assign out_tuser[TU_SAMPLE_VALID] = payo_r.fresh;
  assign out_tuser[TU_MOTION_EVENT] = event_o_r;

endmodule

### sv/imed_checker.sv
module imed_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [imed_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [imed_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import imed_pkg::*;

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an event is only reported for a fresh measurement
  a_event_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[TU_MOTION_EVENT] |-> out_tuser[TU_SAMPLE_VALID])
    else $error("motion event without a fresh sample");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind imu_motion_event_detector_unit imed_checker u_imed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
